// ===== hw/rtl/audio_slot_channel_mapper_top_defines.svh =====
// Assertion macros shared by the checker files.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef AUDIO_SLOT_CHANNEL_MAPPER_TOP_DEFINES_SVH
`define AUDIO_SLOT_CHANNEL_MAPPER_TOP_DEFINES_SVH

// A property that must hold at every edge outside reset.
`define ASCM_HOLDS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When ante is seen, cons must hold at the same edge.
`define ASCM_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ascm_pkg.sv =====
`timescale 1ns / 1ps

package ascm_pkg;

	localparam int MAP_W      = 26;   // highest slot in use is 25
	localparam int SLOT_W     = 5;
	localparam int FRAME_W    = 13;
	localparam int CHAN_W     = 5;
	localparam int DMA_W      = 18;
	localparam int WORD_W     = 32;
	localparam int PCM_W      = 6;
	localparam int PORT_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam int SLOT_BUFFER_SAMPLES_DEF = 8192;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CARD_KIND,
		REG_PORT_ENABLES,
		REG_SPEED_MODE,
		REG_PCM_CHANNELS
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SPEED_SINGLE,
		SPEED_DOUBLE,
		SPEED_QUAD
	} speed_t;

	localparam logic CARD_SIXTEEN     = 1'b0;
	localparam logic CARD_TRIPLE_ADAT = 1'b1;

	localparam logic [MAP_W-1:0] ADAT_SINGLE = MAP_W'(32'h0000_00ff);
	localparam logic [MAP_W-1:0] ADAT_DOUBLE = MAP_W'(32'h0000_00aa);
	localparam logic [MAP_W-1:0] K0_SPDIF    = MAP_W'(32'h3) << 8;
	localparam logic [MAP_W-1:0] K0_LINE     = MAP_W'(32'h3) << 10;
	localparam logic [MAP_W-1:0] K0_EXT      = MAP_W'(32'hf) << 12;
	localparam logic [MAP_W-1:0] K1_SPDIF    = MAP_W'(32'h3) << 24;

	localparam logic [PCM_W-1:0] PCM_CHANNELS_RST = PCM_W'(2);

	typedef struct packed {
		logic              card_kind;
		logic [PORT_W-1:0] port_enables;
		logic [1:0]        speed_mode;
		logic [PCM_W-1:0]  pcm_channels;
	} cfg_t;

	typedef struct packed {
		logic              present;
		logic [SLOT_W-1:0] slot;
	} sel_t;

	// Slots of one ADAT port; quad speed (and the unused fourth code) carries none.
	function automatic logic [MAP_W-1:0] adat_group(logic [1:0] speed);
		logic [MAP_W-1:0] g;
		unique case (speed)
			SPEED_SINGLE: g = ADAT_SINGLE;
			SPEED_DOUBLE: g = ADAT_DOUBLE;
			default:      g = '0;
		endcase
		return g;
	endfunction

	function automatic logic [MAP_W-1:0] slot_bitmap(cfg_t c);
		logic [MAP_W-1:0] map;
		logic [MAP_W-1:0] adat;
		map  = '0;
		adat = adat_group(c.speed_mode);
		if (c.card_kind == CARD_SIXTEEN) begin
			if (c.port_enables[0]) map |= adat;
			if (c.port_enables[1]) map |= K0_SPDIF;
			if (c.port_enables[2]) map |= K0_LINE;
			if (c.port_enables[3]) map |= K0_EXT;
		end else if (c.speed_mode == SPEED_SINGLE || c.speed_mode == SPEED_DOUBLE) begin
			if (c.port_enables[0]) map |= adat;
			if (c.port_enables[1]) map |= adat << 8;
			if (c.port_enables[2]) map |= adat << 16;
			if (c.port_enables[3]) map |= K1_SPDIF;
		end
		return map;
	endfunction

endpackage

// ===== hw/rtl/ascm_cfg_regs.sv =====
`timescale 1ns / 1ps

module ascm_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [ascm_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [ascm_pkg::CFG_DATA_W-1:0]   wr_data,
	output ascm_pkg::cfg_t                    cfg
);

	ascm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.card_kind    <= ascm_pkg::CARD_SIXTEEN;
			cfg_q.port_enables <= '0;
			cfg_q.speed_mode   <= ascm_pkg::SPEED_SINGLE;
			cfg_q.pcm_channels <= ascm_pkg::PCM_CHANNELS_RST;
		end else if (wr_en) begin
			unique case (ascm_pkg::cfg_reg_t'(wr_index))
				ascm_pkg::REG_CARD_KIND:    cfg_q.card_kind    <= wr_data[0];
				ascm_pkg::REG_PORT_ENABLES: cfg_q.port_enables <= wr_data[ascm_pkg::PORT_W-1:0];
				ascm_pkg::REG_SPEED_MODE:   cfg_q.speed_mode   <= wr_data[1:0];
				ascm_pkg::REG_PCM_CHANNELS: cfg_q.pcm_channels <= wr_data[ascm_pkg::PCM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/ascm_slot_sel.sv =====
`timescale 1ns / 1ps

module ascm_slot_sel (
	input  ascm_pkg::cfg_t                  cfg,
	input  logic [ascm_pkg::CHAN_W-1:0]     chan,
	output ascm_pkg::sel_t                  sel
);

	logic [ascm_pkg::MAP_W-1:0]  map;
	logic [ascm_pkg::MAP_W-1:0]  hit;
	logic [ascm_pkg::SLOT_W-1:0] slot;
	logic                        in_range;

	assign map = ascm_pkg::slot_bitmap(cfg);

	// Cutting the map to the first pcm_channels slots only drops channels at or
	// above pcm_channels, so a plain compare stands in for the cut.
	assign in_range = {1'b0, chan} < cfg.pcm_channels;

	// Prefix popcount: slot i is hit when it is set and exactly chan set slots lie below it.
	always_comb begin
		for (int i = 0; i < ascm_pkg::MAP_W; i++) begin
			hit[i] = map[i] && (ascm_pkg::CHAN_W'($countones(
				map & ((ascm_pkg::MAP_W'(1) << i) - ascm_pkg::MAP_W'(1)))) == chan);
		end
	end

	// Encode the one-hot hit vector.
	always_comb begin
		slot = '0;
		for (int i = 0; i < ascm_pkg::MAP_W; i++) begin
			if (hit[i]) slot |= ascm_pkg::SLOT_W'(i);
		end
	end

	assign sel.present = in_range && (|hit);
	assign sel.slot    = sel.present ? slot : '0;

endmodule

// ===== hw/rtl/audio_slot_channel_mapper_top.sv =====
`timescale 1ns / 1ps
// Channel    Handshake              Payload
// ---------  ---------------------  -----------------------------------------------
// command    start / busy           frame_pos, channel_index, sample_word, last_sample
// result     result_valid (strobe)  dma_index, slot_number, channel_present,
//                                   sample_out, last_out
// config     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A word is taken at every edge with start high and busy low, one word per clock;
// its result strobes once it has passed the input register, the slot select logic
// and the result register.
// busy and cfg_ready are held off only in reset and until busy_q clears after it.
// The receiver cannot stall; results are never held back.
module audio_slot_channel_mapper_top #(
	parameter int SLOT_BUFFER_SAMPLES = ascm_pkg::SLOT_BUFFER_SAMPLES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command channel
	input  logic                               start,
	output logic                               busy,
	input  logic [ascm_pkg::FRAME_W-1:0]       frame_pos,
	input  logic [ascm_pkg::CHAN_W-1:0]        channel_index,
	input  logic [ascm_pkg::WORD_W-1:0]        sample_word,
	input  logic                               last_sample,
	// result channel
	output logic                               result_valid,
	output logic [ascm_pkg::DMA_W-1:0]         dma_index,
	output logic [ascm_pkg::SLOT_W-1:0]        slot_number,
	output logic                               channel_present,
	output logic [ascm_pkg::WORD_W-1:0]        sample_out,
	output logic                               last_out,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ascm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ascm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Per-slot stride; the address wraps at the DMA index width.
	localparam logic [ascm_pkg::DMA_W-1:0] BUF_STRIDE =
		ascm_pkg::DMA_W'(SLOT_BUFFER_SAMPLES);

	logic                            busy_q;
	logic                            accept;

	logic                            vld_s1;
	logic [ascm_pkg::FRAME_W-1:0]    frame_s1;
	logic [ascm_pkg::CHAN_W-1:0]     chan_s1;
	logic [ascm_pkg::WORD_W-1:0]     word_s1;
	logic                            last_s1;

	ascm_pkg::cfg_t                  cfg;
	ascm_pkg::sel_t                  sel;
	logic [ascm_pkg::DMA_W-1:0]      dma_next;

	logic                            vld_s2;
	logic [ascm_pkg::DMA_W-1:0]      dma_s2;
	logic [ascm_pkg::SLOT_W-1:0]     slot_s2;
	logic                            present_s2;
	logic [ascm_pkg::WORD_W-1:0]     word_s2;
	logic                            last_s2;

	// Hold busy through reset until this register clears, then stay open every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign accept    = start && !busy_q;

	ascm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register: capture the command word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= frame_pos;
			chan_s1  <= channel_index;
			word_s1  <= sample_word;
			last_s1  <= last_sample;
		end
	end

	// Slot select: the user keeps cfg stable while words are in flight; not enforced.
	ascm_slot_sel u_sel (
		.cfg  (cfg),
		.chan (chan_s1),
		.sel  (sel)
	);

	// Absent channels get a zero address.
	assign dma_next = sel.present
		? ascm_pkg::DMA_W'(ascm_pkg::DMA_W'(sel.slot) * BUF_STRIDE)
			+ ascm_pkg::DMA_W'(frame_s1)
		: '0;

	// Result register: strobe for one cycle per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			dma_s2     <= dma_next;
			slot_s2    <= sel.slot;
			present_s2 <= sel.present;
			word_s2    <= word_s1;
			last_s2    <= last_s1;
		end
	end

	assign result_valid    = vld_s2;
	assign dma_index       = dma_s2;
	assign slot_number     = slot_s2;
	assign channel_present = present_s2;
	assign sample_out      = word_s2;
	assign last_out        = last_s2;

endmodule

// ===== hw/rtl/ascm_checker.sv =====
`timescale 1ns / 1ps
`include "audio_slot_channel_mapper_top_defines.svh"

module ascm_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [ascm_pkg::WORD_W-1:0]        sample_word,
	input  logic                               last_sample,
	input  logic                               result_valid,
	input  logic [ascm_pkg::DMA_W-1:0]         dma_index,
	input  logic [ascm_pkg::SLOT_W-1:0]        slot_number,
	input  logic                               channel_present,
	input  logic [ascm_pkg::WORD_W-1:0]        sample_out,
	input  logic                               last_out
);

	// Every accepted word strobes a result after the input and result registers, and nothing else does.
	`ASCM_HOLDS(a_result_timing, result_valid == $past(start && !busy, 2), "result strobe mismatch")

	// Sample and last flag pass through with the word they came with.
	`ASCM_IMPLIES(a_passthrough, result_valid, sample_out == $past(sample_word, 2) && last_out == $past(last_sample, 2), "passthrough mismatch")

	// A dropped channel carries a zero address and slot.
	`ASCM_IMPLIES(a_absent_zero, result_valid && !channel_present, dma_index == '0 && slot_number == '0, "absent channel not zeroed")

	// A present channel lands on a slot that some port can provide.
	`ASCM_IMPLIES(a_slot_range, result_valid && channel_present, slot_number < ascm_pkg::SLOT_W'(ascm_pkg::MAP_W), "slot out of range")

endmodule

bind audio_slot_channel_mapper_top ascm_checker u_ascm_checker (.*);

// ===== tb/slot_map_checker.sv =====
`timescale 1ns / 1ps

module slot_map_checker #(
	parameter int BUF_SAMPLES = 8192
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [ascm_pkg::FRAME_W-1:0]    frame_pos,
	input  logic [ascm_pkg::CHAN_W-1:0]     channel_index,
	input  logic [ascm_pkg::WORD_W-1:0]     sample_word,
	input  logic                            last_sample,
	input  logic                            result_valid,
	input  logic [ascm_pkg::DMA_W-1:0]      dma_index,
	input  logic [ascm_pkg::SLOT_W-1:0]     slot_number,
	input  logic                            channel_present,
	input  logic [ascm_pkg::WORD_W-1:0]     sample_out,
	input  logic                            last_out,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [ascm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ascm_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatch_count,
	output int                              routes_pending
);
	import ascm_pkg::*;

	typedef struct packed {
		logic [DMA_W-1:0]  dma_index;
		logic [SLOT_W-1:0] slot;
		logic              present;
		logic [WORD_W-1:0] sample;
		logic              last;
	} slot_route_t;

	logic              card_kind_q;
	logic [PORT_W-1:0] ports_q;
	logic [1:0]        speed_q;
	logic [PCM_W-1:0]  pcm_q;
	slot_route_t       expected_routes[$];
	slot_route_t       want_route;

	// Slots carried by the enabled ports; the triple card goes silent at quad speed.
	function automatic logic [31:0] active_slots(logic card, logic [PORT_W-1:0] ports,
			logic [1:0] speed);
		logic [31:0] adat;
		logic [31:0] map;
		if (speed == SPEED_SINGLE)
			adat = 32'h0000_00ff;
		else if (speed == SPEED_DOUBLE)
			adat = 32'h0000_00aa;
		else
			adat = 32'h0;
		map = '0;
		if (card == CARD_SIXTEEN) begin
			if (ports[0]) map |= adat;
			if (ports[1]) map |= 32'h3 << 8;
			if (ports[2]) map |= 32'h3 << 10;
			if (ports[3]) map |= 32'hf << 12;
		end else if (speed == SPEED_SINGLE || speed == SPEED_DOUBLE) begin
			if (ports[0]) map |= adat;
			if (ports[1]) map |= adat << 8;
			if (ports[2]) map |= adat << 16;
			if (ports[3]) map |= 32'h3 << 24;
		end
		return map;
	endfunction

	// Channel c takes the c-th active slot, provided c is below the channel count.
	function automatic slot_route_t predict_route(logic [FRAME_W-1:0] frame,
			logic [CHAN_W-1:0] chan, logic [WORD_W-1:0] sample, logic last);
		logic [31:0] map;
		int          seen;
		slot_route_t r;
		map      = active_slots(card_kind_q, ports_q, speed_q);
		r        = '0;
		r.sample = sample;
		r.last   = last;
		seen     = 0;
		for (int b = 0; b < 32; b++) begin
			if (map[b]) begin
				if (seen == int'(chan) && seen < int'(pcm_q) && !r.present) begin
					r.present   = 1'b1;
					r.slot      = SLOT_W'(b);
					r.dma_index = DMA_W'(b * BUF_SAMPLES + int'(frame));
				end
				seen++;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card_kind_q    = CARD_SIXTEEN;
			ports_q        = '0;
			speed_q        = SPEED_SINGLE;
			pcm_q          = PCM_CHANNELS_RST;
			mismatch_count = 0;
			routes_pending = 0;
			expected_routes.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CARD_KIND:    card_kind_q = cfg_data[0];
					REG_PORT_ENABLES: ports_q     = cfg_data[PORT_W-1:0];
					REG_SPEED_MODE:   speed_q     = cfg_data[1:0];
					REG_PCM_CHANNELS: pcm_q       = cfg_data[PCM_W-1:0];
					default: ;
				endcase
			end
			if (result_valid) begin
				if (expected_routes.size() == 0) begin
					report_mismatch("unexpected result, slot", 32'(slot_number), '0);
				end else begin
					want_route = expected_routes.pop_front();
					if (dma_index !== want_route.dma_index)
						report_mismatch("dma_index", 32'(dma_index), 32'(want_route.dma_index));
					if (slot_number !== want_route.slot)
						report_mismatch("slot_number", 32'(slot_number), 32'(want_route.slot));
					if (channel_present !== want_route.present)
						report_mismatch("channel_present", 32'(channel_present),
							32'(want_route.present));
					if (sample_out !== want_route.sample)
						report_mismatch("sample_out", sample_out, want_route.sample);
					if (last_out !== want_route.last)
						report_mismatch("last_out", 32'(last_out), 32'(want_route.last));
				end
			end
			if (start && !busy)
				expected_routes.push_back(predict_route(frame_pos, channel_index,
					sample_word, last_sample));
			routes_pending = expected_routes.size();
		end
	end

endmodule

// ===== tb/tb_audio_slot_channel_mapper_top.sv =====
`timescale 1ns / 1ps

module tb_audio_slot_channel_mapper_top;
	import ascm_pkg::*;

	localparam int         CYCLE_LIMIT    = 200000;
	localparam int         RANDOM_WORDS   = 1100;
	// The fourth speed code is unused by the hardware; it must act like quad speed.
	localparam logic [1:0] SPEED_RESERVED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [FRAME_W-1:0]    frame_pos;
	logic [CHAN_W-1:0]     channel_index;
	logic [WORD_W-1:0]     sample_word;
	logic                  last_sample;
	logic                  result_valid;
	logic [DMA_W-1:0]      dma_index;
	logic [SLOT_W-1:0]     slot_number;
	logic                  channel_present;
	logic [WORD_W-1:0]     sample_out;
	logic                  last_out;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int    mismatches;
	int    pending;
	int    cycles = 0;
	int    words_sent = 0;
	logic  gaps_on = 1'b1;
	logic  [PCM_W-1:0] cur_pcm;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	audio_slot_channel_mapper_top uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.frame_pos       (frame_pos),
		.channel_index   (channel_index),
		.sample_word     (sample_word),
		.last_sample     (last_sample),
		.result_valid    (result_valid),
		.dma_index       (dma_index),
		.slot_number     (slot_number),
		.channel_present (channel_present),
		.sample_out      (sample_out),
		.last_out        (last_out),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// The checker watches all three channels on its own and only hands back counts.
	slot_map_checker #(
		.BUF_SAMPLES (SLOT_BUFFER_SAMPLES_DEF)
	) route_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.frame_pos       (frame_pos),
		.channel_index   (channel_index),
		.sample_word     (sample_word),
		.last_sample     (last_sample),
		.result_valid    (result_valid),
		.dma_index       (dma_index),
		.slot_number     (slot_number),
		.channel_present (channel_present),
		.sample_out      (sample_out),
		.last_out        (last_out),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatches),
		.routes_pending  (pending)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("audio_slot_channel_mapper_top verification failed");
			$finish;
		end
	end

	// Present one command word at a falling edge and hold it until busy lets it in.
	// Return at the falling edge right after the accepting rising edge, with start
	// still high, so a back-to-back word only overwrites the payload.
	task automatic send_word(input logic [FRAME_W-1:0] f, input logic [CHAN_W-1:0] c,
			input logic [WORD_W-1:0] s, input logic l);
		start         <= 1'b1;
		frame_pos     <= f;
		channel_index <= c;
		sample_word   <= s;
		last_sample   <= l;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// Drop start for a pause; n is always at least one so start never toggles twice
	// in one time step.
	task automatic pause_words(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Insert a one-cycle gap in about one word in ten, unless gaps are switched off.
	task automatic maybe_gap();
		if (gaps_on && $urandom_range(0, 99) < 10)
			pause_words(1);
	endtask

	// Hold off until every predicted word has come back. Every word yields exactly
	// one result, so an empty queue means the pipeline is empty; a short margin is
	// waited out anyway.
	task automatic drain();
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// One register write; valid stays high on return so consecutive writes
	// never lower and raise it in the same step.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		while (!cfg_ready)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Reprogram all four registers with the block idle. Unused upper data bits
	// get random values; the block must ignore them.
	task automatic apply_settings(input logic card, input logic [PORT_W-1:0] ports,
			input logic [1:0] speed, input logic [PCM_W-1:0] pcm);
		drain();
		write_reg(REG_CARD_KIND, {5'($urandom), card});
		write_reg(REG_PORT_ENABLES, {2'($urandom), ports});
		write_reg(REG_SPEED_MODE, {4'($urandom), speed});
		write_reg(REG_PCM_CHANNELS, pcm);
		cfg_valid <= 1'b0;
		cur_pcm = pcm;
		@(negedge clk);
	endtask

	// Random word with every field fully random: covers all bits and the
	// out-of-range channels.
	task automatic send_noise();
		send_word(FRAME_W'($urandom), CHAN_W'($urandom), $urandom, 1'($urandom));
		maybe_gap();
	endtask

	// A run of interleaved frames: channels 0..n-1 per frame position, last flag
	// usually set on the final channel. Some frames are cut short to break the run.
	task automatic send_frames(input int n_frames);
		logic [FRAME_W-1:0] fpos;
		int                 width;
		int                 stop_at;
		fpos  = FRAME_W'($urandom);
		width = (cur_pcm >= 1 && cur_pcm <= 32) ? int'(cur_pcm) : $urandom_range(1, 32);
		for (int k = 0; k < n_frames; k++) begin
			stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, width) : width;
			for (int ch = 0; ch < stop_at; ch++) begin
				send_word(fpos, CHAN_W'(ch), $urandom,
					(ch == width - 1) ? ($urandom_range(0, 3) != 0) : 1'b0);
				maybe_gap();
			end
			fpos++;
		end
	endtask

	initial begin
		logic              pressure_done;
		logic [PCM_W-1:0]  pick_pcm;
		int                phase_end;

		pressure_done = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		frame_pos     = '0;
		channel_index = '0;
		sample_word   = '0;
		last_sample   = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_CARD_KIND;
		cfg_data      = '0;
		cur_pcm       = PCM_CHANNELS_RST;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out of reset no port is enabled: every channel is absent, payload passes.
		send_word('0, '0, '0, 1'b0);
		send_word('1, '1, '1, 1'b1);

		// Full sixteen-slot card: last slot, first absent channel, highest channel.
		apply_settings(CARD_SIXTEEN, 4'hf, SPEED_SINGLE, 6'd32);
		send_word('0, 5'd0, 32'h0000_0001, 1'b0);
		send_word('1, 5'd15, 32'h8000_0000, 1'b1);
		send_word('1, 5'd16, 32'h5555_5555, 1'b0);
		send_word('0, 5'd31, 32'haaaa_aaaa, 1'b1);

		// Triple card, all ports, channel count beyond the slot count: top slot 25.
		apply_settings(CARD_TRIPLE_ADAT, 4'hf, SPEED_SINGLE, 6'd63);
		send_word('1, 5'd24, $urandom, 1'b0);
		send_word('1, 5'd25, $urandom, 1'b1);
		send_word('1, 5'd26, $urandom, 1'b0);

		// Double speed keeps only the odd ADAT slots.
		apply_settings(CARD_TRIPLE_ADAT, 4'hf, SPEED_DOUBLE, 6'd32);
		send_word('0, 5'd0, $urandom, 1'b0);
		send_word('1, 5'd13, $urandom, 1'b0);
		send_word('1, 5'd14, $urandom, 1'b1);

		// Quad speed on the triple card leaves no slot at all.
		apply_settings(CARD_TRIPLE_ADAT, 4'hf, SPEED_QUAD, 6'd32);
		send_word('0, 5'd0, $urandom, 1'b1);

		// Reserved speed code: ADAT group drops out, the other ports remain.
		apply_settings(CARD_SIXTEEN, 4'hf, SPEED_RESERVED, 6'd32);
		send_word('0, 5'd0, $urandom, 1'b0);
		send_word('1, 5'd7, $urandom, 1'b0);
		send_word('1, 5'd8, $urandom, 1'b1);

		// Zero channels: nothing is kept.
		apply_settings(CARD_SIXTEEN, 4'hf, SPEED_SINGLE, 6'd0);
		send_word('0, 5'd0, $urandom, 1'b1);

		// Count cut below the slot count.
		apply_settings(CARD_SIXTEEN, 4'b0101, SPEED_DOUBLE, 6'd3);
		send_word('1, 5'd2, $urandom, 1'b0);
		send_word('1, 5'd3, $urandom, 1'b1);

		// Random phases: new settings each time, mostly frame runs, some noise.
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 7))
				0:       pick_pcm = 6'd0;
				1:       pick_pcm = 6'd1;
				2:       pick_pcm = 6'd32;
				3:       pick_pcm = 6'd63;
				4:       pick_pcm = 6'd26;
				default: pick_pcm = PCM_W'($urandom_range(1, 32));
			endcase
			apply_settings(1'($urandom),
				($urandom_range(0, 1) != 0) ? 4'hf : PORT_W'($urandom),
				2'($urandom), pick_pcm);
			phase_end = words_sent + $urandom_range(60, 140);
			while (words_sent < phase_end && words_sent < RANDOM_WORDS) begin
				// Keep a long stretch gap-free so back-to-back words stream.
				gaps_on = !(words_sent >= 300 && words_sent < 500);
				if ($urandom_range(0, 4) == 0)
					send_noise();
				else
					send_frames($urandom_range(1, 4));
				// Hold off once mid-phase until the pipeline has emptied.
				if (!pressure_done && words_sent >= 600) begin
					drain();
					pressure_done = 1'b1;
				end
			end
		end

		// Flush: wait out every outstanding result plus some latency margin.
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("audio_slot_channel_mapper_top verification clean");
		else
			$display("audio_slot_channel_mapper_top verification failed");
		$finish;
	end

endmodule
